// File: sv/phlc_pkg.sv
// Package for the presence hold lamp controller.
// Item types, register indexes, widths and clock limits; no dependencies.
package phlc_pkg;

  localparam int WINDOW   = 10;
  localparam int CHANNELS = 7;

  localparam int ECHO_W  = 7;
  localparam int CNT_W   = 4;
  localparam int HOLD_W  = 16;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;
  localparam logic [HOLD_W-1:0] CHAIN_INIT = HOLD_W'(1);

  localparam logic [SEC_W:0]  SEC_LAST  = (SEC_W+1)'(59);
  localparam logic [MIN_W:0]  MIN_LAST  = (MIN_W+1)'(59);
  localparam logic [HOUR_W:0] HOUR_LAST = (HOUR_W+1)'(23);
  localparam logic [HOUR_W-1:0] NIGHT_FROM = HOUR_W'(19);
  localparam logic [HOUR_W-1:0] NIGHT_TO   = HOUR_W'(7);

  localparam logic [CNT_W-1:0]  RST_THRESHOLD = CNT_W'(5);
  localparam logic [HOLD_W-1:0] RST_NIGHT     = HOLD_W'(20);
  localparam logic [HOLD_W-1:0] RST_DAY       = HOLD_W'(30);
  localparam logic [HOLD_W-1:0] RST_COMPANION = HOLD_W'(10);
  localparam logic [HOUR_W-1:0] RST_HOUR      = HOUR_W'(12);
  localparam logic [MIN_W-1:0]  RST_MINUTE    = MIN_W'(30);
  localparam logic [SEC_W-1:0]  RST_SECOND    = SEC_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOTE_THRESHOLD  = 3'd0,
    REG_NIGHT_HOLD      = 3'd1,
    REG_DAY_HOLD        = 3'd2,
    REG_COMPANION_LIMIT = 3'd3,
    REG_START_HOUR      = 3'd4,
    REG_START_MINUTE    = 3'd5,
    REG_START_SECOND    = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [ECHO_W-1:0] echo_bits;
  } in_item_t;

  typedef struct packed {
    logic              lamp_on;
    logic [HOLD_W-1:0] largest_hold;
    logic [HOLD_W-1:0] second_hold;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } out_item_t;

  typedef struct packed {
    logic sample;
    logic tick;
    logic old_bit;
    logic new_bit;
  } lane_ctrl_t;

  typedef struct packed {
    logic [HOLD_W-1:0] night_hold;
    logic [HOLD_W-1:0] day_hold;
    logic [HOLD_W-1:0] companion_limit;
  } lamp_cfg_t;

endpackage

// File: sv/phlc_lane.sv
// One sensor channel: window count of set bits and saturating hold counter.
// Depends on phlc_pkg.
module phlc_lane import phlc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]  threshold_i,
  output logic [HOLD_W-1:0] hold_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [HOLD_W-1:0] hold_q, hold_d;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.sample && (ctrl_i.old_bit != ctrl_i.new_bit)) begin
      if (ctrl_i.old_bit) begin
        count_d = count_q - CNT_W'(1);
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    hold_d = hold_q;
    if (ctrl_i.tick) begin
      if (count_q <= threshold_i) begin
        if (hold_q != HOLD_MAX) begin
          hold_d = hold_q + HOLD_W'(1);
        end
      end else begin
        hold_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hold_q  <= '0;
    end else begin
      count_q <= count_d;
      hold_q  <= hold_d;
    end
  end

  assign hold_o = hold_q;

endmodule

// File: sv/phlc_merge.sv
// Merging stage: ordered compare chain over the lane hold values, lamp decision
// and the registered result item. Depends on phlc_pkg.
module phlc_merge import phlc_pkg::*; (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic [CHANNELS-1:0][HOLD_W-1:0]  holds_i,
  input  lamp_cfg_t                        cfg_i,
  input  logic [HOUR_W-1:0]                hour_i,
  input  logic [MIN_W-1:0]                 minute_i,
  input  logic [SEC_W-1:0]                 second_i,
  output out_item_t                        item_o
);

  logic [HOLD_W-1:0] largest, runner, limit;
  logic              night;
  out_item_t         item_q, item_d;

  always_comb begin
    largest = CHAIN_INIT;
    runner  = CHAIN_INIT;
    for (int c = 0; c < CHANNELS; c++) begin
      if (holds_i[c] >= largest) begin
        runner  = largest;
        largest = holds_i[c];
      end else if ((holds_i[c] > runner) && (holds_i[c] < largest)) begin
        runner = holds_i[c];
      end
    end
  end

  assign night = (hour_i >= NIGHT_FROM) || (hour_i < NIGHT_TO);
  assign limit = night ? cfg_i.night_hold : cfg_i.day_hold;

  always_comb begin
    item_d.lamp_on      = (largest > limit) && (runner < cfg_i.companion_limit);
    item_d.largest_hold = largest;
    item_d.second_hold  = runner;
    item_d.hour         = hour_i;
    item_d.minute       = minute_i;
    item_d.second       = second_i;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: sv/presence_hold_lamp_controller.sv
// Presence hold lamp controller: top level with sample window, clock and handshake.
// One item per clock; the lanes update at the accepting edge and the compare chain
// result is registered when the pending item advances, so the result item is offered
// after that. The input stalls only while a pending item waits on a held result.
// Depends on phlc_pkg, phlc_lane and phlc_merge.
module presence_hold_lamp_controller import phlc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CNT_W-1:0]  thr_q;
  lamp_cfg_t         lamp_cfg_q;
  logic [HOUR_W-1:0] hour_q, hour_d;
  logic [MIN_W-1:0]  min_q, min_d;
  logic [SEC_W-1:0]  sec_q, sec_d;

  logic [WINDOW-1:0][CHANNELS-1:0] ring_q;
  logic [CHANNELS-1:0]             sample_bits;
  logic [CHANNELS-1:0][HOLD_W-1:0] holds;

  logic accept, do_sample, do_tick, advance;
  logic pend_q, out_valid_q;

  logic [SEC_W:0]  sec_inc;
  logic [MIN_W:0]  min_inc;
  logic [HOUR_W:0] hour_inc;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign do_sample  = accept && (in_item_i.func == FUNC_SAMPLE);
  assign do_tick    = accept && (in_item_i.func == FUNC_TICK);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_bits
    if (c < ECHO_W) begin : g_echo
      assign sample_bits[c] = in_item_i.echo_bits[c];
    end else begin : g_none
      assign sample_bits[c] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
    end else if (do_sample) begin
      ring_q <= {ring_q[WINDOW-2:0], sample_bits};
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl.sample  = do_sample;
    assign ctrl.tick    = do_tick;
    assign ctrl.old_bit = ring_q[WINDOW-1][c];
    assign ctrl.new_bit = sample_bits[c];

    phlc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .threshold_i (thr_q),
      .hold_o      (holds[c])
    );
  end

  always_comb begin
    sec_inc  = {1'b0, sec_q} + (SEC_W+1)'(1);
    sec_d    = sec_inc[SEC_W-1:0];
    min_inc  = {1'b0, min_q};
    if (sec_inc > SEC_LAST) begin
      sec_d   = '0;
      min_inc = {1'b0, min_q} + (MIN_W+1)'(1);
    end
    min_d    = min_inc[MIN_W-1:0];
    hour_inc = {1'b0, hour_q};
    if (min_inc > MIN_LAST) begin
      min_d    = '0;
      hour_inc = {1'b0, hour_q} + (HOUR_W+1)'(1);
    end
    hour_d = hour_inc[HOUR_W-1:0];
    if (hour_inc > HOUR_LAST) begin
      hour_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q                      <= RST_THRESHOLD;
      lamp_cfg_q.night_hold      <= RST_NIGHT;
      lamp_cfg_q.day_hold        <= RST_DAY;
      lamp_cfg_q.companion_limit <= RST_COMPANION;
      hour_q                     <= RST_HOUR;
      min_q                      <= RST_MINUTE;
      sec_q                      <= RST_SECOND;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VOTE_THRESHOLD:  thr_q                      <= cfg_data_i[CNT_W-1:0];
        REG_NIGHT_HOLD:      lamp_cfg_q.night_hold      <= cfg_data_i[HOLD_W-1:0];
        REG_DAY_HOLD:        lamp_cfg_q.day_hold        <= cfg_data_i[HOLD_W-1:0];
        REG_COMPANION_LIMIT: lamp_cfg_q.companion_limit <= cfg_data_i[HOLD_W-1:0];
        REG_START_HOUR:      hour_q                     <= cfg_data_i[HOUR_W-1:0];
        REG_START_MINUTE:    min_q                      <= cfg_data_i[MIN_W-1:0];
        REG_START_SECOND:    sec_q                      <= cfg_data_i[SEC_W-1:0];
        default: ;
      endcase
    end else if (do_tick) begin
      hour_q <= hour_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (advance) begin
        pend_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= pend_q;
      end
    end
  end

  phlc_merge u_merge (
    .clk_i    (clk_i),
    .load_i   (pend_q && advance),
    .holds_i  (holds),
    .cfg_i    (lamp_cfg_q),
    .hour_i   (hour_q),
    .minute_i (min_q),
    .second_i (sec_q),
    .item_o   (out_item_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/phlc_checker.sv
// Port-level checks for the presence hold lamp controller, bound to the top level.
// Depends on phlc_pkg.
module phlc_checker import phlc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_item_t             out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result two cycles after an accepted item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_chain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.largest_hold >= out_item_o.second_hold) &&
                    (out_item_o.second_hold != '0))
    else $error("compare chain order broken");

endmodule

bind presence_hold_lamp_controller phlc_checker u_phlc_checker (.*);

// File: test/tb_presence_hold_lamp_controller.sv
// Self-checking testbench for presence_hold_lamp_controller: random and directed items
// through valid/ready with bursts of idling, predicted status compared field by field.
// Depends on phlc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_presence_hold_lamp_controller;
  import phlc_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 90;
  localparam int BURST_TICKS   = 60;
  localparam int PRINT_CAP     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  presence_hold_lamp_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  in_item_t  sensor_events_q [$];
  out_item_t status_q [$];
  out_item_t want;
  int        idle_pct    = 20;
  int        send_gap    = 0;
  int        recv_gap    = 0;
  int        mismatches  = 0;
  int        cycle_count = 0;

  logic [ECHO_W-1:0] ring_words [WINDOW];
  int                ring_ptr;
  logic [CNT_W-1:0]  bit_counts [CHANNELS];
  logic [HOLD_W-1:0] hold_secs [CHANNELS];
  int                tod_h, tod_m, tod_s;
  logic [CNT_W-1:0]  m_threshold;
  logic [HOLD_W-1:0] m_night, m_day, m_companion;

  function automatic in_item_t event_of(input func_e f, input logic [ECHO_W-1:0] bits);
    in_item_t ev;
    ev.func      = f;
    ev.echo_bits = bits;
    return ev;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_VOTE_THRESHOLD:  m_threshold = d[CNT_W-1:0];
      REG_NIGHT_HOLD:      m_night     = d[HOLD_W-1:0];
      REG_DAY_HOLD:        m_day       = d[HOLD_W-1:0];
      REG_COMPANION_LIMIT: m_companion = d[HOLD_W-1:0];
      REG_START_HOUR:      tod_h       = int'(d[HOUR_W-1:0]);
      REG_START_MINUTE:    tod_m       = int'(d[MIN_W-1:0]);
      REG_START_SECOND:    tod_s       = int'(d[SEC_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic out_item_t compute_status(input in_item_t ev);
    out_item_t         r;
    logic [ECHO_W-1:0] old_w;
    int                top, runner;
    logic [HOLD_W-1:0] limit;
    if (ev.func == FUNC_TICK) begin
      tod_s++;
      if (tod_s > int'(SEC_LAST)) begin
        tod_m++;
        tod_s = 0;
      end
      if (tod_m > int'(MIN_LAST)) begin
        tod_h++;
        tod_m = 0;
      end
      if (tod_h > int'(HOUR_LAST)) tod_h = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (bit_counts[c] <= m_threshold) begin
          if (hold_secs[c] != HOLD_MAX) hold_secs[c] = hold_secs[c] + 1'b1;
        end else begin
          hold_secs[c] = '0;
        end
      end
    end else begin
      old_w = ring_words[ring_ptr];
      ring_words[ring_ptr] = ev.echo_bits;
      for (int c = 0; c < CHANNELS; c++) begin
        if (old_w[c] != ev.echo_bits[c])
          bit_counts[c] = old_w[c] ? bit_counts[c] - 1'b1 : bit_counts[c] + 1'b1;
      end
      ring_ptr = (ring_ptr == WINDOW - 1) ? 0 : ring_ptr + 1;
    end
    top    = 1;
    runner = 1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(hold_secs[c]) >= top) begin
        runner = top;
        top    = int'(hold_secs[c]);
      end else if (int'(hold_secs[c]) > runner && int'(hold_secs[c]) < top) begin
        runner = int'(hold_secs[c]);
      end
    end
    limit = (tod_h >= int'(NIGHT_FROM) || tod_h < int'(NIGHT_TO)) ? m_night : m_day;
    r.lamp_on      = (top > int'(limit)) && (runner < int'(m_companion));
    r.largest_hold = HOLD_W'(top);
    r.second_hold  = HOLD_W'(runner);
    r.hour         = HOUR_W'(tod_h);
    r.minute       = MIN_W'(tod_m);
    r.second       = SEC_W'(tod_s);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (mismatches < PRINT_CAP)
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, exp_val);
    mismatches++;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val, input int w);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data = ((data >> w) << w) | CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (sensor_events_q.size() != 0 || in_valid_i || status_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (sensor_events_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= sensor_events_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        if (sensor_events_q.size() != 0) send_gap <= $urandom_range(11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap    <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(99) < idle_pct) begin
      recv_gap    <= $urandom_range(11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          flag_mismatch("item with none awaited", 32'(out_item_o.largest_hold), 0);
        end else begin
          want = status_q.pop_front();
          if (out_item_o.lamp_on !== want.lamp_on)
            flag_mismatch("lamp_on", 32'(out_item_o.lamp_on), 32'(want.lamp_on));
          if (out_item_o.largest_hold !== want.largest_hold)
            flag_mismatch("largest_hold", 32'(out_item_o.largest_hold),
                          32'(want.largest_hold));
          if (out_item_o.second_hold !== want.second_hold)
            flag_mismatch("second_hold", 32'(out_item_o.second_hold),
                          32'(want.second_hold));
          if (out_item_o.hour !== want.hour)
            flag_mismatch("hour", 32'(out_item_o.hour), 32'(want.hour));
          if (out_item_o.minute !== want.minute)
            flag_mismatch("minute", 32'(out_item_o.minute), 32'(want.minute));
          if (out_item_o.second !== want.second)
            flag_mismatch("second", 32'(out_item_o.second), 32'(want.second));
        end
      end
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) status_q.push_back(compute_status(in_item_i));
    end
  end

  initial begin
    logic [ECHO_W-1:0] quiet, bits;
    int pick;
    int reg_width [7]    = '{CNT_W, HOLD_W, HOLD_W, HOLD_W, HOUR_W, MIN_W, SEC_W};
    int idle_choices [4] = '{0, 5, 15, 30};
    int preset_h [5]     = '{23, 31, 18, 6, 18};
    int preset_m [5]     = '{59, 63, 59, 59, 0};
    int preset_s [5]     = '{59, 63, 59, 59, 0};

    for (int i = 0; i < WINDOW; i++) ring_words[i] = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      bit_counts[c] = '0;
      hold_secs[c]  = '0;
    end
    ring_ptr    = 0;
    m_threshold = RST_THRESHOLD;
    m_night     = RST_NIGHT;
    m_day       = RST_DAY;
    m_companion = RST_COMPANION;
    tod_h       = int'(RST_HOUR);
    tod_m       = int'(RST_MINUTE);
    tod_s       = int'(RST_SECOND);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // equal holds, a cleared chain, then sample extremes; echo bits ride along on ticks
    @(negedge clk_i);
    sensor_events_q.push_back(event_of(FUNC_TICK, 7'h7F));
    sensor_events_q.push_back(event_of(FUNC_TICK, 7'h00));
    repeat (6) sensor_events_q.push_back(event_of(FUNC_SAMPLE, 7'h7E));
    sensor_events_q.push_back(event_of(FUNC_TICK, 7'h00));
    sensor_events_q.push_back(event_of(FUNC_SAMPLE, 7'h00));
    sensor_events_q.push_back(event_of(FUNC_SAMPLE, 7'h7F));
    sensor_events_q.push_back(event_of(FUNC_SAMPLE, 7'h55));
    sensor_events_q.push_back(event_of(FUNC_SAMPLE, 7'h2A));
    sensor_events_q.push_back(event_of(FUNC_TICK, 7'h55));

    settle();
    set_reg(REG_UNUSED, 0, 0);
    set_reg(REG_VOTE_THRESHOLD, 3, CNT_W);
    set_reg(REG_NIGHT_HOLD, 0, HOLD_W);
    set_reg(REG_COMPANION_LIMIT, 65535, HOLD_W);
    // rollover, out-of-range presets and the night/day boundaries
    for (int i = 0; i < 5; i++) begin
      settle();
      if (i == 3) set_reg(REG_DAY_HOLD, 0, HOLD_W);
      set_reg(REG_START_HOUR, preset_h[i], HOUR_W);
      set_reg(REG_START_MINUTE, preset_m[i], MIN_W);
      set_reg(REG_START_SECOND, preset_s[i], SEC_W);
      @(negedge clk_i);
      sensor_events_q.push_back(event_of(FUNC_TICK, ECHO_W'($urandom)));
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      idle_pct = idle_choices[$urandom_range(3)];
      if (p < 2) begin
        for (int i = 0; i < 7; i++)
          set_reg(CFG_IDX_W'(i), (p == 0) ? 0 : (1 << reg_width[i]) - 1, reg_width[i]);
      end else begin
        set_reg(REG_VOTE_THRESHOLD, $urandom_range(1, 10), CNT_W);
        set_reg(REG_NIGHT_HOLD, $urandom_range(0, 40), HOLD_W);
        set_reg(REG_DAY_HOLD, $urandom_range(0, 40), HOLD_W);
        set_reg(REG_COMPANION_LIMIT, $urandom_range(1, 20), HOLD_W);
        if ($urandom_range(1)) begin
          set_reg(REG_START_HOUR, $urandom_range(0, 23), HOUR_W);
          set_reg(REG_START_MINUTE, $urandom_range(57, 59), MIN_W);
          set_reg(REG_START_SECOND, $urandom_range(0, 59), SEC_W);
        end
      end
      @(negedge clk_i);
      quiet = ECHO_W'(1 << $urandom_range(CHANNELS - 1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(49) == 0)
          quiet = $urandom_range(1) ? ECHO_W'($urandom) : ECHO_W'(1 << $urandom_range(6));
        pick = $urandom_range(99);
        if (pick < 40) begin
          sensor_events_q.push_back(event_of(FUNC_TICK, ECHO_W'($urandom)));
        end else if (pick < 85) begin
          for (int c = 0; c < ECHO_W; c++)
            bits[c] = quiet[c] ? ($urandom_range(9) == 0) : ($urandom_range(9) != 0);
          sensor_events_q.push_back(event_of(FUNC_SAMPLE, bits));
        end else begin
          sensor_events_q.push_back(event_of(FUNC_SAMPLE, ECHO_W'($urandom)));
        end
      end
    end

    // run one channel's hold past the night limit at full rate, the others held busy
    settle();
    idle_pct = 0;
    set_reg(REG_VOTE_THRESHOLD, 0, CNT_W);
    set_reg(REG_NIGHT_HOLD, 40, HOLD_W);
    set_reg(REG_DAY_HOLD, 40, HOLD_W);
    set_reg(REG_COMPANION_LIMIT, 65535, HOLD_W);
    set_reg(REG_START_HOUR, 22, HOUR_W);
    set_reg(REG_START_MINUTE, 0, MIN_W);
    set_reg(REG_START_SECOND, 0, SEC_W);
    @(negedge clk_i);
    repeat (WINDOW) sensor_events_q.push_back(event_of(FUNC_SAMPLE, 7'h7E));
    repeat (BURST_TICKS) sensor_events_q.push_back(event_of(FUNC_TICK, 7'h00));

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
